>>> hw/rtl/assert_macros.svh
// Assertion macros included by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define ASSERT_IMPL(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> hw/rtl/hscb_pkg.sv
// Package of types, constants and helpers for the harmonic sin/cos basis core.
package hscb_pkg;

    // Field and register widths.
    localparam int TIME_W      = 40;
    localparam int RECIP_W     = 48;
    localparam int NUM_W       = 3;
    localparam int FREQ_W      = 16;
    localparam int IDX_W       = 2;
    localparam int VAL_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // Turn fraction width and fixed-point lane width of the polynomial.
    localparam int FRAC_W = 56;
    localparam int LANE_W = 31;

    // Default parameter values.
    localparam int MAX_FREQS_DEF  = 4;
    localparam int PHASE_BITS_DEF = 24;

    // Reset values of the configuration registers.
    localparam logic signed [TIME_W-1:0] START_TIME_RST  = '0;
    localparam logic [RECIP_W-1:0]       CYCLE_RECIP_RST = 48'd3257812230;
    localparam logic [NUM_W-1:0]         NUM_FREQS_RST   = 3'd1;
    localparam logic [FREQ_W-1:0]        FREQ_STEP_RST   = 16'd256;

    // One quarter turn in Q30.
    localparam logic [LANE_W-1:0] Q30_ONE = 31'h4000_0000;

    // Odd Taylor coefficients of sin(pi/2 * x) in Q30, lowest order first.
    localparam logic [LANE_W-1:0] POLY_Q30 [7] = '{
        31'd1686629713,
        31'd693598668,
        31'd85569306,
        31'd5026996,
        31'd172272,
        31'd3864,
        31'd61
    };

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_TIME  = 3'd0,
        REG_CYCLE_RECIP = 3'd1,
        REG_NUM_FREQS   = 3'd2,
        REG_FREQ_0      = 3'd3,
        REG_FREQ_1      = 3'd4,
        REG_FREQ_2      = 3'd5,
        REG_FREQ_3      = 3'd6
    } reg_index_t;

    // Quadrant of the phase.
    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    // One frequency issued by the sequencer into the datapath.
    typedef struct packed {
        logic                     valid;
        logic signed [TIME_W-1:0] sample_time;
        logic [IDX_W-1:0]         k;
        logic                     last;
    } issue_t;

    // Tag that travels alongside the datapath.
    typedef struct packed {
        logic [IDX_W-1:0] k;
        logic             last;
        quad_t            quad;
    } tag_t;

    // One polynomial lane: Horner accumulator, squared argument, argument.
    typedef struct packed {
        logic [LANE_W-1:0] acc;
        logic [LANE_W-1:0] x2;
        logic [LANE_W-1:0] x;
    } lane_t;

    // Index of the last frequency in use, with zero read as one and the
    // count saturated at the number of frequency slots.
    function automatic logic [IDX_W-1:0] last_index(logic [NUM_W-1:0] num, int max_freqs);
        logic [IDX_W-1:0] result;
        if (num == '0)
            result = '0;
        else if (int'(num) > max_freqs)
            result = IDX_W'(max_freqs - 1);
        else
            result = IDX_W'(num - NUM_W'(1));
        return result;
    endfunction

endpackage

>>> hw/rtl/hscb_seq.sv
// Front sequencer: holds one time sample and issues its frequencies one per cycle while adv is high.
module hscb_seq #(
    parameter int MAX_FREQS = hscb_pkg::MAX_FREQS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [hscb_pkg::TIME_W-1:0]  sample_time,
    input  logic [hscb_pkg::NUM_W-1:0]          num_freqs,
    input  logic                                adv,
    output hscb_pkg::issue_t                    issue
);
    import hscb_pkg::*;

    logic                     busy_reg;
    logic                     busy_next;
    logic signed [TIME_W-1:0] time_reg;
    logic [IDX_W-1:0]         k_reg;
    logic [IDX_W-1:0]         k_next;
    logic [IDX_W-1:0]         last_k;
    logic                     is_last;
    logic                     take;

    // Position of the current frequency within the sample.
    assign last_k  = last_index(num_freqs, MAX_FREQS);
    assign is_last = (k_reg == last_k);

    // A new word is taken when nothing is held or the last frequency leaves now.
    assign in_stall = busy_reg && !(adv && is_last);
    assign take     = in_valid && !in_stall;

    // Next hold state and frequency counter.
    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (take)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
        else if (adv && busy_reg)
        begin
            if (is_last)
                busy_next = 1'b0;
            else
                k_next = k_reg + IDX_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    // Held sample time.
    always_ff @(posedge clk)
    begin
        if (take)
            time_reg <= sample_time;
    end

    assign issue.valid       = busy_reg;
    assign issue.sample_time = time_reg;
    assign issue.k           = k_reg;
    assign issue.last        = is_last;

endmodule

>>> hw/rtl/hscb_cell.sv
// One Horner step of the sine polynomial: acc <= coef - acc * x2, in Q30.
module hscb_cell (
    input  logic                               clk,
    input  logic                               en,
    input  logic [hscb_pkg::LANE_W-1:0]        coef,
    input  hscb_pkg::lane_t                    lane_in,
    output hscb_pkg::lane_t                    lane_out
);
    import hscb_pkg::*;

    logic [2*LANE_W-1:0] prod;
    logic [LANE_W:0]     diff;
    lane_t               lane_next;
    lane_t               lane_reg;

    // Multiply, drop 30 fraction bits, subtract from the coefficient.
    always_comb
    begin
        prod          = lane_in.acc * lane_in.x2;
        diff          = {1'b0, coef} - prod[2*LANE_W-1:30];
        lane_next.acc = diff[LANE_W-1:0];
        lane_next.x2  = lane_in.x2;
        lane_next.x   = lane_in.x;
    end

    // Hand the lane to the next cell.
    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

>>> hw/rtl/harmonic_sin_cos_basis_core.sv
// Top level of the harmonic sin/cos basis core: phase datapath, cell chains, output word.
//
// Each accepted time word yields one result word per frequency in use (num_freqs, read
// as 1 when zero and capped at MAX_FREQS), in order, the final one marked by last.
// The front sequencer issues one frequency per cycle while the pipeline advances, so
// a sample holds the input until the next sample is taken in the cycle its last
// frequency leaves; the sustained rate is one result word per clock when nothing stalls.
// The datapath is a fixed pipeline of a 41x48 phase product in partial products, a
// product with the frequency, the quadrant split, a squaring stage, six Horner cells
// per lane (sin and cos in parallel) and a final product. A stall on the output
// freezes the whole pipeline. The user must write configuration only while the block
// is idle; the block itself does not enforce it.
module harmonic_sin_cos_basis_core #(
    parameter int MAX_FREQS  = hscb_pkg::MAX_FREQS_DEF,
    parameter int PHASE_BITS = hscb_pkg::PHASE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [hscb_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [hscb_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [hscb_pkg::TIME_W-1:0]      sample_time,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [hscb_pkg::IDX_W-1:0]              freq_index,
    output logic signed [hscb_pkg::VAL_W-1:0]       cos_value,
    output logic signed [hscb_pkg::VAL_W-1:0]       sin_value,
    output logic                                    last
);
    import hscb_pkg::*;

    `include "assert_macros.svh"

    localparam int K_W      = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
    localparam int CELLS    = 6;
    localparam int STG_X    = 6;
    localparam int LINE_LEN = 15;

    // Configuration registers.
    logic signed [TIME_W-1:0] start_time_reg;
    logic [RECIP_W-1:0]       cycle_recip_reg;
    logic [NUM_W-1:0]         num_freqs_reg;
    logic [FREQ_W-1:0]        freq_reg [MAX_FREQS];

    // Pipeline control.
    logic                     adv;
    issue_t                   issue;
    logic [IDX_W-1:0]         last_k;
    logic [LINE_LEN-1:0]      valid_reg;
    logic [LINE_LEN-1:0]      valid_next;
    tag_t                     tag_reg  [LINE_LEN];
    tag_t                     tag_next [LINE_LEN];

    // Phase datapath.
    logic signed [TIME_W:0]   d41;
    logic [FRAC_W-1:0]        diff_reg, diff_next;
    logic [FREQ_W-1:0]        fq_reg, fq_next;
    logic [51:0]              prod_ll, prod_lh, prod_hl;
    logic [7:0]               prod_hh;
    logic [51:0]              p_ll_reg;
    logic [31:0]              p_lh_reg;
    logic [27:0]              p_hl_reg;
    logic [3:0]               p_hh_reg;
    logic [FRAC_W-1:0]        sum_lo_reg, sum_lo_next;
    logic [27:0]              sum_hi_reg, sum_hi_next;
    logic [FRAC_W-1:0]        base_reg, base_next;
    logic [43:0]              pf_lo, pf_hi;
    logic [43:0]              pf_lo_reg;
    logic [27:0]              pf_hi_reg;
    logic [FRAC_W-1:0]        frac;
    logic [PHASE_BITS-1:0]    phase_reg, phase_next;
    logic [31:0]              turn;
    logic [LANE_W-1:0]        xs_reg, xs_next;
    logic [LANE_W-1:0]        xc_reg, xc_next;
    logic [2*LANE_W-1:0]      sq_s, sq_c;
    lane_t                    lane0_s_next, lane0_c_next;
    lane_t                    lane_s [CELLS+1];
    lane_t                    lane_c [CELLS+1];
    logic [2*LANE_W-1:0]      fin_s, fin_c;
    logic [LANE_W-1:0]        s_reg, s_next;
    logic [LANE_W-1:0]        c_reg, c_next;

    // Output register.
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         freq_index_reg;
    logic signed [VAL_W-1:0]  cos_reg, cos_next;
    logic signed [VAL_W-1:0]  sin_reg, sin_next;
    logic                     last_reg;

    // Round a Q30 magnitude to Q15, saturate at +1, then apply the sign.
    function automatic logic [VAL_W-1:0] to_q15(logic [LANE_W-1:0] v, logic neg);
        logic [LANE_W:0]  r;
        logic [VAL_W-1:0] m;
        r = {1'b0, v} + (LANE_W+1)'(16384);
        m = (r[LANE_W:15] > 17'd32767) ? 16'd32767 : r[30:15];
        return neg ? (16'd0 - m) : m;
    endfunction

    // The pipeline moves whenever the output word is empty or being taken.
    assign adv    = !out_valid_reg || !out_stall;
    assign last_k = last_index(num_freqs_reg, MAX_FREQS);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg  <= START_TIME_RST;
            cycle_recip_reg <= CYCLE_RECIP_RST;
            num_freqs_reg   <= NUM_FREQS_RST;
            for (int i = 0; i < MAX_FREQS; i++)
                freq_reg[i] <= FREQ_W'(int'(FREQ_STEP_RST) * (i + 1));
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_TIME:  start_time_reg  <= cfg_data[TIME_W-1:0];
                REG_CYCLE_RECIP: cycle_recip_reg <= cfg_data[RECIP_W-1:0];
                REG_NUM_FREQS:   num_freqs_reg   <= cfg_data[NUM_W-1:0];
                default:
                begin
                    for (int i = 0; i < MAX_FREQS; i++)
                    begin
                        if (cfg_index == CFG_INDEX_W'(int'(REG_FREQ_0) + i))
                            freq_reg[i] <= cfg_data[FREQ_W-1:0];
                    end
                end
            endcase
        end
    end

    // Sequencer.
    hscb_seq #(
        .MAX_FREQS (MAX_FREQS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_time (sample_time),
        .num_freqs   (num_freqs_reg),
        .adv         (adv),
        .issue       (issue)
    );

    // Valid and tag line alongside the datapath; the quadrant joins at the x stage.
    always_comb
    begin
        valid_next[0]    = issue.valid;
        tag_next[0].k    = issue.k;
        tag_next[0].last = issue.last;
        tag_next[0].quad = QUAD_I;
        for (int i = 1; i < LINE_LEN; i++)
        begin
            valid_next[i] = valid_reg[i-1];
            tag_next[i]   = tag_reg[i-1];
        end
        tag_next[STG_X].quad = quad_t'(turn[31:30]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LINE_LEN; i++)
                tag_reg[i] <= tag_next[i];
        end
    end

    // Phase arithmetic, modulo 2^56: difference, base product, frequency product.
    always_comb
    begin
        d41       = {issue.sample_time[TIME_W-1], issue.sample_time}
                  - {start_time_reg[TIME_W-1], start_time_reg};
        diff_next = {{(FRAC_W-TIME_W-1){d41[TIME_W]}}, d41};
        // The frequency is picked for the word that moves into the base stage.
        fq_next   = freq_reg[tag_reg[2].k[K_W-1:0]];

        prod_ll = diff_reg[27:0] * cycle_recip_reg[23:0];
        prod_lh = diff_reg[27:0] * cycle_recip_reg[47:24];
        prod_hl = diff_reg[55:28] * cycle_recip_reg[23:0];
        prod_hh = diff_reg[31:28] * cycle_recip_reg[27:24];

        sum_lo_next = {4'd0, p_ll_reg} + {p_lh_reg, 24'd0};
        sum_hi_next = p_hl_reg + {p_hh_reg, 24'd0};
        base_next   = sum_lo_reg + {sum_hi_reg, 28'd0};

        pf_lo = base_reg[27:0] * fq_reg;
        pf_hi = base_reg[55:28] * fq_reg;

        frac       = {12'd0, pf_lo_reg} + {pf_hi_reg, 28'd0};
        phase_next = frac[FRAC_W-1 -: PHASE_BITS];
    end

    // Quadrant split and the two polynomial arguments.
    always_comb
    begin
        turn    = 32'(phase_reg) << (32 - PHASE_BITS);
        xs_next = {1'b0, turn[29:0]};
        xc_next = Q30_ONE - {1'b0, turn[29:0]};

        sq_s = xs_reg * xs_reg;
        sq_c = xc_reg * xc_reg;
        lane0_s_next.acc = POLY_Q30[CELLS];
        lane0_s_next.x2  = sq_s[60:30];
        lane0_s_next.x   = xs_reg;
        lane0_c_next.acc = POLY_Q30[CELLS];
        lane0_c_next.x2  = sq_c[60:30];
        lane0_c_next.x   = xc_reg;
    end

    // Datapath registers ahead of the cell chains.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg   <= diff_next;
            fq_reg     <= fq_next;
            p_ll_reg   <= prod_ll;
            p_lh_reg   <= prod_lh[31:0];
            p_hl_reg   <= prod_hl[27:0];
            p_hh_reg   <= prod_hh[3:0];
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
            base_reg   <= base_next;
            pf_lo_reg  <= pf_lo;
            pf_hi_reg  <= pf_hi[27:0];
            phase_reg  <= phase_next;
            xs_reg     <= xs_next;
            xc_reg     <= xc_next;
            lane_s[0]  <= lane0_s_next;
            lane_c[0]  <= lane0_c_next;
        end
    end

    // Horner cell chains for sin(x) and sin(1 - x).
    for (genvar j = 0; j < CELLS; j++)
    begin : g_cell
        hscb_cell u_cell_s (
            .clk      (clk),
            .en       (adv),
            .coef     (POLY_Q30[CELLS-1-j]),
            .lane_in  (lane_s[j]),
            .lane_out (lane_s[j+1])
        );
        hscb_cell u_cell_c (
            .clk      (clk),
            .en       (adv),
            .coef     (POLY_Q30[CELLS-1-j]),
            .lane_in  (lane_c[j]),
            .lane_out (lane_c[j+1])
        );
    end

    // Final multiply by the argument.
    always_comb
    begin
        fin_s  = lane_s[CELLS].acc * lane_s[CELLS].x;
        fin_c  = lane_c[CELLS].acc * lane_c[CELLS].x;
        s_next = fin_s[60:30];
        c_next = fin_c[60:30];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
    end

    // Map the quarter-turn values onto cos and sin by quadrant.
    always_comb
    begin
        case (tag_reg[LINE_LEN-1].quad)
            QUAD_I:
            begin
                cos_next = to_q15(c_reg, 1'b0);
                sin_next = to_q15(s_reg, 1'b0);
            end
            QUAD_II:
            begin
                cos_next = to_q15(s_reg, 1'b1);
                sin_next = to_q15(c_reg, 1'b0);
            end
            QUAD_III:
            begin
                cos_next = to_q15(c_reg, 1'b1);
                sin_next = to_q15(s_reg, 1'b1);
            end
            default:
            begin
                cos_next = to_q15(s_reg, 1'b0);
                sin_next = to_q15(c_reg, 1'b1);
            end
        endcase
    end

    // Output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_reg[LINE_LEN-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_reg[LINE_LEN-1])
        begin
            freq_index_reg <= tag_reg[LINE_LEN-1].k;
            last_reg       <= tag_reg[LINE_LEN-1].last;
            cos_reg        <= cos_next;
            sin_reg        <= sin_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign freq_index = freq_index_reg;
    assign cos_value  = cos_reg;
    assign sin_value  = sin_reg;
    assign last       = last_reg;

    // A taken sample starts at the first frequency.
    `ASSERT_NEXT(a_seq_load, in_valid && !in_stall, issue.valid && (issue.k == '0), "sample not loaded at first frequency")
    // The mark sits on the last frequency in use and nowhere else.
    `ASSERT_IMPL(a_last_mark, out_valid_reg, last_reg == (freq_index_reg == last_k), "last mark on wrong frequency")
    // Behind an unmarked result the rest of its sample is still in flight.
    `ASSERT_IMPL(a_tail_in_flight, out_valid_reg && !last_reg, issue.valid || (|valid_reg), "results of a sample lost")

endmodule
